// ===== sv/u8vf_pkg.sv =====
// shared types, constants and code point helpers for the utf-8 vietnamese fold stream
package u8vf_pkg;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [7:0] LIMIT_RESET = 8'd10;
    localparam logic [7:0] QMARK       = 8'h3F;
    localparam logic [7:0] SPACE       = 8'h20;

    // input request payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } u8vf_in_t;

    // result request payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } u8vf_out_t;

    // configuration as seen by the fold core
    typedef struct packed {
        logic       mode;
        logic [7:0] limit;
    } u8vf_cfg_t;

    // the results of one input byte, handed to the output buffer
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            marker;
        logic            str_end;
    } u8vf_burst_t;

    // encoded form of one code point
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } u8vf_enc_t;

    // sequence length from a lead byte, zero when it is no valid lead
    function automatic logic [2:0] lead_len(input logic [7:0] x);
        logic [2:0] r;
        if (x[7] == 1'b0)
        begin
            r = 3'd1;
        end
        else if (x[7:5] == 3'b110)
        begin
            r = 3'd2;
        end
        else if (x[7:4] == 4'b1110)
        begin
            r = 3'd3;
        end
        else if (x[7:3] == 5'b11110)
        begin
            r = 3'd4;
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    // vietnamese vowels and d fold to the plain capital, a..z to upper case
    function automatic logic [20:0] fold_cp(input logic [20:0] c);
        logic [7:0]  v;
        logic [20:0] r;
        v = c[7:0] & 8'hDF;
        r = c;
        if (c inside {[21'h61 : 21'h7A]})
        begin
            r = c - 21'h20;
        end
        else if (c inside {[21'hC0 : 21'hFF]})
        begin
            if (v inside {[8'hC0 : 8'hC3]})
            begin
                r = 21'h41;
            end
            else if (v inside {[8'hC8 : 8'hCA]})
            begin
                r = 21'h45;
            end
            else if (v inside {[8'hCC : 8'hCD]})
            begin
                r = 21'h49;
            end
            else if (v inside {[8'hD2 : 8'hD5]})
            begin
                r = 21'h4F;
            end
            else if (v inside {[8'hD9 : 8'hDA]})
            begin
                r = 21'h55;
            end
            else if (v == 8'hDD)
            begin
                r = 21'h59;
            end
        end
        else if (c inside {21'h102, 21'h103})
        begin
            r = 21'h41;
        end
        else if (c inside {21'h110, 21'h111})
        begin
            r = 21'h44;
        end
        else if (c inside {21'h128, 21'h129})
        begin
            r = 21'h49;
        end
        else if (c inside {21'h168, 21'h169, 21'h1AF, 21'h1B0})
        begin
            r = 21'h55;
        end
        else if (c inside {21'h1A0, 21'h1A1})
        begin
            r = 21'h4F;
        end
        else if (c inside {[21'h1EA0 : 21'h1EB7]})
        begin
            r = 21'h41;
        end
        else if (c inside {[21'h1EB8 : 21'h1EC7]})
        begin
            r = 21'h45;
        end
        else if (c inside {[21'h1EC8 : 21'h1ECB]})
        begin
            r = 21'h49;
        end
        else if (c inside {[21'h1ECC : 21'h1EE3]})
        begin
            r = 21'h4F;
        end
        else if (c inside {[21'h1EE4 : 21'h1EF1]})
        begin
            r = 21'h55;
        end
        else if (c inside {[21'h1EF2 : 21'h1EF9]})
        begin
            r = 21'h59;
        end
        return r;
    endfunction

    // shortest utf-8 form of a code point
    function automatic u8vf_enc_t encode_cp(input logic [20:0] c);
        u8vf_enc_t e;
        e.b = '0;
        if (c < 21'h80)
        begin
            e.b[0] = c[7:0];
            e.len  = 3'd1;
        end
        else if (c < 21'h800)
        begin
            e.b[0] = {3'b110, c[10:6]};
            e.b[1] = {2'b10, c[5:0]};
            e.len  = 3'd2;
        end
        else if (c < 21'h10000)
        begin
            e.b[0] = {4'b1110, c[15:12]};
            e.b[1] = {2'b10, c[11:6]};
            e.b[2] = {2'b10, c[5:0]};
            e.len  = 3'd3;
        end
        else
        begin
            e.b[0] = {5'b11110, c[20:18]};
            e.b[1] = {2'b10, c[17:12]};
            e.b[2] = {2'b10, c[11:6]};
            e.b[3] = {2'b10, c[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

    // saturating add into the 9 bit emitted count
    function automatic logic [8:0] sat_add(input logic [8:0] a, input logic [2:0] d);
        logic [9:0] s;
        s = {1'b0, a} + {7'b0, d};
        return s[9] ? 9'h1FF : s[8:0];
    endfunction

endpackage

// ===== sv/u8vf_in_reg.sv =====
// input register stage that holds one byte request until the fold core takes it
module u8vf_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  u8vf_pkg::u8vf_in_t in_data,
    input  logic               advance,
    output logic               hold_valid,
    output u8vf_pkg::u8vf_in_t hold_data
);

    logic               vld_reg;
    logic               vld_next;
    logic               load;
    u8vf_pkg::u8vf_in_t data_reg;

    // stall while a held request is not taken this cycle
    assign in_stall   = vld_reg & ~advance;
    assign load       = in_valid & ~in_stall;
    assign vld_next   = load | (vld_reg & ~advance);
    assign hold_valid = vld_reg;
    assign hold_data  = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== sv/u8vf_fold_core.sv =====
// decode, fold, initials filtering and string state for one byte per cycle while fire is high
module u8vf_fold_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8vf_pkg::u8vf_cfg_t   cfg,
    input  logic                  fire,
    input  u8vf_pkg::u8vf_in_t    in_data,
    output u8vf_pkg::u8vf_burst_t burst
);

    logic [7:0] pend_reg [3];
    logic [1:0] pcnt_reg;
    logic [1:0] pcnt_next;
    logic       ws_reg;
    logic       ws_next;
    logic [8:0] count_reg;
    logic [8:0] count_next;
    logic       stop_reg;
    logic       stop_next;

    logic [7:0]  b;
    logic        lst;
    logic [2:0]  b_len;
    logic [2:0]  p_len;
    logic [2:0]  c3;
    logic        is_cont;
    logic        complete;
    logic        extend;
    logic [1:0]  nq;
    logic        fin_present;
    logic        new_lead;
    logic [20:0] fin_cp;
    logic [20:0] fc;
    u8vf_pkg::u8vf_enc_t enc;
    logic        run_emit;
    logic [8:0]  cnt_a;
    logic        stop_a;
    logic        ws_a;
    logic        proc_fin;
    logic        is_space;
    logic        is_skip;
    logic        fin_emit;
    logic        ws_b;
    logic [8:0]  cnt_b;
    logic        stop_b;
    logic [2:0]  qc;
    logic [2:0]  total;
    logic        wr_en;
    logic [1:0]  wr_idx;

    // split the pending prefix plus the new byte into code points
    always_comb
    begin
        b        = in_data.in_byte;
        lst      = in_data.in_last;
        b_len    = u8vf_pkg::lead_len(b);
        p_len    = u8vf_pkg::lead_len(pend_reg[0]);
        c3       = {1'b0, pcnt_reg};
        is_cont  = (b[7:6] == 2'b10);
        complete = (pcnt_reg != 2'd0) && is_cont && ((c3 + 3'd1) == p_len);
        extend   = (pcnt_reg != 2'd0) && is_cont && ((c3 + 3'd1) < p_len) && !lst;
        // a broken prefix gives one '?' per buffered byte, then the new byte alone
        nq          = (complete || extend) ? 2'd0 : pcnt_reg;
        fin_present = 1'b0;
        new_lead    = 1'b0;
        fin_cp      = '0;
        if (complete)
        begin
            fin_present = 1'b1;
            case (p_len)
                3'd2:    fin_cp = {10'b0, pend_reg[0][4:0], b[5:0]};
                3'd3:    fin_cp = {5'b0, pend_reg[0][3:0], pend_reg[1][5:0], b[5:0]};
                default: fin_cp = {pend_reg[0][2:0], pend_reg[1][5:0],
                                   pend_reg[2][5:0], b[5:0]};
            endcase
        end
        else if (!extend)
        begin
            if (b_len == 3'd1)
            begin
                fin_present = 1'b1;
                fin_cp      = {13'b0, b};
            end
            else if ((b_len == 3'd0) || lst)
            begin
                fin_present = 1'b1;
                fin_cp      = {13'b0, u8vf_pkg::QMARK};
            end
            else
            begin
                new_lead = 1'b1;
            end
        end
    end

    // fold, encode and apply the initials filter
    always_comb
    begin
        fc       = u8vf_pkg::fold_cp(fin_cp);
        enc      = u8vf_pkg::encode_cp(fc);
        is_space = (fc == {13'b0, u8vf_pkg::SPACE});
        is_skip  = (fc inside {21'h2D, 21'h28, 21'h29, 21'h7B, 21'h5B, 21'h26, 21'h3B});
        // initials mode: the '?' run shows at most its first character
        run_emit = cfg.mode && (nq != 2'd0) && ws_reg;
        cnt_a    = run_emit ? u8vf_pkg::sat_add(count_reg, 3'd1) : count_reg;
        stop_a   = run_emit && (cnt_a > {1'b0, cfg.limit});
        ws_a     = run_emit ? 1'b0 : ws_reg;
        proc_fin = fin_present && !stop_a;
        if (cfg.mode)
        begin
            fin_emit = proc_fin && !is_space && !is_skip && ws_a;
            qc       = run_emit ? 3'd1 : 3'd0;
        end
        else
        begin
            fin_emit = fin_present;
            qc       = {1'b0, nq};
        end
        if (proc_fin && is_space)
        begin
            ws_b = 1'b1;
        end
        else if (fin_emit)
        begin
            ws_b = 1'b0;
        end
        else
        begin
            ws_b = ws_a;
        end
        cnt_b  = fin_emit ? u8vf_pkg::sat_add(cnt_a, enc.len) : cnt_a;
        stop_b = cfg.mode && (stop_a || (fin_emit && (cnt_b > {1'b0, cfg.limit})));
        total  = stop_reg ? 3'd0 : (qc + (fin_emit ? enc.len : 3'd0));
    end

    // result bytes: the '?' run first, then the encoded code point
    always_comb
    begin
        burst.marker  = (total == 3'd0) && lst;
        burst.str_end = lst;
        burst.cnt     = burst.marker ? 3'd1 : total;
        for (int i = 0; i < 4; i++)
        begin
            if (burst.marker)
            begin
                burst.bytes[i] = 8'h00;
            end
            else if (qc > 3'(i))
            begin
                burst.bytes[i] = u8vf_pkg::QMARK;
            end
            else if (qc != 3'd0)
            begin
                burst.bytes[i] = enc.b[0];
            end
            else
            begin
                burst.bytes[i] = enc.b[i];
            end
        end
    end

    // next string state
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = 2'd0;
        if (stop_reg || stop_b)
        begin
            pcnt_next = 2'd0;
        end
        else if (extend)
        begin
            pcnt_next = pcnt_reg + 2'd1;
            wr_en     = 1'b1;
            wr_idx    = pcnt_reg;
        end
        else if (new_lead)
        begin
            pcnt_next = 2'd1;
            wr_en     = 1'b1;
        end
        else
        begin
            pcnt_next = 2'd0;
        end
        if (lst)
        begin
            pcnt_next  = 2'd0;
            ws_next    = 1'b1;
            count_next = 9'd0;
            stop_next  = 1'b0;
        end
        else if (stop_reg || !cfg.mode)
        begin
            ws_next    = ws_reg;
            count_next = count_reg;
            stop_next  = stop_reg;
        end
        else
        begin
            ws_next    = ws_b;
            count_next = cnt_b;
            stop_next  = stop_b;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg  <= 2'd0;
            ws_reg    <= 1'b1;
            count_reg <= 9'd0;
            stop_reg  <= 1'b0;
        end
        else if (fire)
        begin
            pcnt_reg  <= pcnt_next;
            ws_reg    <= ws_next;
            count_reg <= count_next;
            stop_reg  <= stop_next;
        end
    end

    // bytes of an unfinished sequence
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            pend_reg[wr_idx] <= b;
        end
    end

endmodule

// ===== sv/u8vf_out_buf.sv =====
// result buffer that sends the bytes of one input request one per cycle while the output does not stall
module u8vf_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  u8vf_pkg::u8vf_burst_t burst,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output u8vf_pkg::u8vf_out_t   out_data
);

    logic [2:0]      cnt_reg;
    logic [2:0]      cnt_next;
    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic [3:0][7:0] bytes_reg;
    logic            marker_reg;
    logic            end_reg;
    logic            take;

    assign out_valid = (cnt_reg != 3'd0);
    assign take      = out_valid & ~out_stall;
    // room for a new set of results once the last one leaves
    assign free      = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && ~out_stall);

    always_comb
    begin
        out_data.out_byte   = bytes_reg[pos_reg];
        out_data.byte_valid = ~marker_reg;
        out_data.run_last   = (cnt_reg == 3'd1);
        out_data.string_end = (cnt_reg == 3'd1) && end_reg;
    end

    // remaining count and read position
    always_comb
    begin
        if (fire)
        begin
            cnt_next = burst.cnt;
            pos_next = 2'd0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
            pos_next = pos_reg + 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            pos_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            bytes_reg  <= burst.bytes;
            marker_reg <= burst.marker;
            end_reg    <= burst.str_end;
        end
    end

endmodule

// ===== sv/utf8_vietnamese_fold_stream_core.sv =====
// top level of the utf-8 vietnamese fold stream
//
// The input channel takes one raw byte of a utf-8 string per request, with
// in_last on the final byte. The output channel returns the folded utf-8
// bytes, one per request; run_last marks the last result of an input byte and
// string_end the last result of a string. A string whose final byte gives no
// output still ends with one end-only marker (byte_valid low).
// The first result of a byte passes through the input register, then the
// result register, before it is offered.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the output does not stall; a byte that gives more results holds
// the input until each of them has left the four-entry result register.
// Bytes that give no result still pass through the fold core.
// A stall on the output holds the current result; the input then stalls once
// the held input byte cannot move into the result register.
// Reset clears both channels, the pending sequence and the word state, and
// sets mode 0 and an initials limit of 10. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must do so only while no request
// is in flight, as the block itself does not enforce this.
module utf8_vietnamese_fold_stream_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  u8vf_pkg::u8vf_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output u8vf_pkg::u8vf_out_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);

    logic                  mode_reg;
    logic [7:0]            limit_reg;
    u8vf_pkg::u8vf_cfg_t   cfg;
    logic                  hold_valid;
    u8vf_pkg::u8vf_in_t    hold_data;
    logic                  free;
    logic                  fire;
    u8vf_pkg::u8vf_burst_t burst;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            limit_reg <= u8vf_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                u8vf_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                u8vf_pkg::CFG_LIMIT: limit_reg <= cfg_data;
                default:             mode_reg  <= mode_reg;
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.limit = limit_reg;

    // held byte moves on when the result register has room
    assign fire = hold_valid & free;

    u8vf_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (fire),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    u8vf_fold_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (fire),
        .in_data (hold_data),
        .burst   (burst)
    );

    u8vf_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .burst     (burst),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/u8vf_checker.sv =====
// port-level checks on the result channel of the fold stream, bound to the top level
module u8vf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input u8vf_pkg::u8vf_out_t out_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // the end of a string is also the end of its byte's results
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.string_end |-> out_data.run_last)
        else $error("string end without run last");

    // an end-only marker closes the string
    a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.run_last && out_data.string_end)
        else $error("end-only marker not at string end");

    // an end-only marker carries a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'h00)
        else $error("end-only marker with nonzero byte");

endmodule

bind utf8_vietnamese_fold_stream_core u8vf_checker u_chk (.*);
